[hw/rtl/dtb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtb_pkg
// Shared types, codes and the sequencer program of the dilated time base.
// ----------------------------------------------------------------------------
package dtb_pkg;

  localparam logic [23:0] GAIN_ONE = 24'h010000;

  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_SET    = 2'd1;
  localparam logic [1:0] KIND_REARM  = 2'd2;

  localparam logic [1:0] REG_GAIN     = 2'd0;
  localparam logic [1:0] REG_PERIOD_0 = 2'd1;
  localparam logic [1:0] REG_PERIOD_1 = 2'd2;
  localparam logic [1:0] REG_PERIOD_2 = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] external_time;
    logic [31:0] elapsed;
    logic [63:0] set_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] clock_now;
    logic [63:0] dilated_elapsed;
    logic        corrected;
  } out_item_t;

  typedef logic [4:0] pc_t;

  localparam pc_t P_WAIT    = 5'd0;
  localparam pc_t P_KIND    = 5'd1;
  localparam pc_t P_GAIN    = 5'd2;
  localparam pc_t P_MUL_EL  = 5'd3;
  localparam pc_t P_ADD_EL  = 5'd4;
  localparam pc_t P_CHK     = 5'd5;
  localparam pc_t P_DUE     = 5'd6;
  localparam pc_t P_BASE    = 5'd7;
  localparam pc_t P_TRUE    = 5'd8;
  localparam pc_t P_MUL_LO  = 5'd9;
  localparam pc_t P_ACC_LO  = 5'd10;
  localparam pc_t P_MUL_HI  = 5'd11;
  localparam pc_t P_ACC_HI  = 5'd12;
  localparam pc_t P_SNAP    = 5'd13;
  localparam pc_t P_ARM     = 5'd14;
  localparam pc_t P_NEXT    = 5'd15;
  localparam pc_t P_DONE    = 5'd16;
  localparam pc_t P_SPECIAL = 5'd17;
  localparam pc_t P_MISC    = 5'd18;
  localparam pc_t P_EMIT    = 5'd19;

  typedef enum logic [4:0] {
    U_NONE,
    U_LOAD,
    U_MUL_EL,
    U_ADD_EL,
    U_BASE,
    U_TRUE,
    U_MUL_LO,
    U_ACC_LO,
    U_MUL_HI,
    U_ACC_HI,
    U_SNAP,
    U_ARM,
    U_NEXT,
    U_DONE,
    U_SPECIAL,
    U_MISC,
    U_EMIT
  } uop_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_NOT_UPDATE,
    C_GAIN_PLAIN,
    C_ARM,
    C_NOT_DUE,
    C_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  function automatic ucode_t ucode_rom(pc_t pc);
    ucode_t w;
    case (pc)
      P_WAIT:    w = '{U_LOAD,    C_NO_ITEM,    P_WAIT};
      P_KIND:    w = '{U_NONE,    C_NOT_UPDATE, P_MISC};
      P_GAIN:    w = '{U_NONE,    C_GAIN_PLAIN, P_SPECIAL};
      P_MUL_EL:  w = '{U_MUL_EL,  C_NEVER,      P_WAIT};
      P_ADD_EL:  w = '{U_ADD_EL,  C_NEVER,      P_WAIT};
      P_CHK:     w = '{U_NONE,    C_ARM,        P_ARM};
      P_DUE:     w = '{U_NONE,    C_NOT_DUE,    P_NEXT};
      P_BASE:    w = '{U_BASE,    C_NEVER,      P_WAIT};
      P_TRUE:    w = '{U_TRUE,    C_NEVER,      P_WAIT};
      P_MUL_LO:  w = '{U_MUL_LO,  C_NEVER,      P_WAIT};
      P_ACC_LO:  w = '{U_ACC_LO,  C_NEVER,      P_WAIT};
      P_MUL_HI:  w = '{U_MUL_HI,  C_NEVER,      P_WAIT};
      P_ACC_HI:  w = '{U_ACC_HI,  C_NEVER,      P_WAIT};
      P_SNAP:    w = '{U_SNAP,    C_ALWAYS,     P_ARM};
      P_ARM:     w = '{U_ARM,     C_NEVER,      P_WAIT};
      P_NEXT:    w = '{U_NEXT,    C_MORE,       P_CHK};
      P_DONE:    w = '{U_DONE,    C_ALWAYS,     P_EMIT};
      P_SPECIAL: w = '{U_SPECIAL, C_ALWAYS,     P_EMIT};
      P_MISC:    w = '{U_MISC,    C_NEVER,      P_WAIT};
      P_EMIT:    w = '{U_EMIT,    C_OUT_BUSY,   P_EMIT};
      default:   w = '{U_NONE,    C_ALWAYS,     P_WAIT};
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/dilated_time_base.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dilated_time_base
// Scaled clock with periodic accuracy checks, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// One item is worked on at a time, and a new item is taken only after the result
// of the one before has been placed in the output register. Set, re-arm and
// unused items pass through the miscellaneous step to the emit step, and
// updates at a gain of exactly 1.0 or 0 through the special step. Other updates
// scale and add the elapsed time, then visit each check in turn: it is re-armed
// after a snap or a pending re-arm, passed over if not yet due, and otherwise
// run, snapping the clock if it is off, and re-armed. A result that is still
// waiting in the output register holds the last step until it is taken. Every
// scaled product goes through one shared 32 by 24 bit multiplier, a check's in two halves.
module dilated_time_base #(
  parameter int NUM_CHECKS = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  dtb_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output dtb_pkg::out_item_t out_item,
  input  logic               cfg_write_enable,
  input  logic [1:0]         cfg_index,
  input  logic [39:0]        cfg_write_data
);

  localparam int IDX_W = (NUM_CHECKS > 1) ? $clog2(NUM_CHECKS) : 1;

  dtb_pkg::pc_t      pc;
  dtb_pkg::pc_t      pc_next;
  dtb_pkg::ucode_t   uw;
  logic              cond_true;

  logic [23:0]       gain;
  logic [39:0]       period [3];
  logic [63:0]       clock_value;
  logic              pending;
  logic              snapped;
  logic [IDX_W-1:0]  idx;

  dtb_pkg::in_item_t item;
  logic [55:0]       prod;
  logic [31:0]       mul_a;
  logic [63:0]       tval;
  logic [63:0]       acc;
  logic [63:0]       delta;
  logic [63:0]       last_clock [NUM_CHECKS];
  logic [63:0]       deadline [NUM_CHECKS];

  logic [39:0]       per_sel;
  logic [63:0]       dl_sel;
  logic              accept;
  logic              out_busy;

  assign uw       = dtb_pkg::ucode_rom(pc);
  assign in_stall = (pc != dtb_pkg::P_WAIT);
  assign accept   = in_valid && (pc == dtb_pkg::P_WAIT);
  assign out_busy = out_valid && out_stall;
  assign per_sel  = period[2'(idx)];
  assign dl_sel   = deadline[idx];

  always_comb begin
    case (uw.cond)
      dtb_pkg::C_NEVER:      cond_true = 1'b0;
      dtb_pkg::C_ALWAYS:     cond_true = 1'b1;
      dtb_pkg::C_NO_ITEM:    cond_true = !in_valid;
      dtb_pkg::C_NOT_UPDATE: cond_true = (item.kind != dtb_pkg::KIND_UPDATE);
      dtb_pkg::C_GAIN_PLAIN: cond_true = (gain == dtb_pkg::GAIN_ONE) || (gain == 24'd0);
      dtb_pkg::C_ARM:        cond_true = snapped || pending;
      dtb_pkg::C_NOT_DUE:    cond_true = (item.external_time < dl_sel);
      dtb_pkg::C_MORE:       cond_true = (idx != IDX_W'(NUM_CHECKS - 1));
      dtb_pkg::C_OUT_BUSY:   cond_true = out_busy;
      default:               cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_true) begin
      pc_next = uw.target;
    end else begin
      pc_next = pc + 5'd1;
    end
  end

  always_comb begin
    case (uw.op)
      dtb_pkg::U_MUL_LO: mul_a = tval[31:0];
      dtb_pkg::U_MUL_HI: mul_a = tval[63:32];
      default:           mul_a = item.elapsed;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc          <= dtb_pkg::P_WAIT;
      out_valid   <= 1'b0;
      gain        <= dtb_pkg::GAIN_ONE;
      period[0]   <= 40'd1000000000;
      period[1]   <= 40'd100000000;
      period[2]   <= 40'd10000000;
      clock_value <= 64'd0;
      pending     <= 1'b1;
      snapped     <= 1'b0;
      idx         <= '0;
    end else begin
      pc <= pc_next;
      if ((uw.op == dtb_pkg::U_EMIT) && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (uw.op)
        dtb_pkg::U_LOAD: begin
          snapped <= 1'b0;
        end
        dtb_pkg::U_ADD_EL: begin
          clock_value <= clock_value + {24'd0, prod[55:16]};
          idx         <= '0;
        end
        dtb_pkg::U_SNAP: begin
          if (clock_value != acc) begin
            clock_value <= acc;
            snapped     <= 1'b1;
          end
        end
        dtb_pkg::U_NEXT: begin
          idx <= idx + 1'b1;
        end
        dtb_pkg::U_DONE: begin
          pending <= 1'b0;
        end
        dtb_pkg::U_SPECIAL: begin
          if (gain == dtb_pkg::GAIN_ONE) begin
            clock_value <= clock_value + {32'd0, item.elapsed};
          end
        end
        dtb_pkg::U_MISC: begin
          if (item.kind == dtb_pkg::KIND_SET) begin
            clock_value <= item.set_value;
            pending     <= 1'b1;
          end else if (item.kind == dtb_pkg::KIND_REARM) begin
            pending <= 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (cfg_write_enable) begin
        case (cfg_index)
          dtb_pkg::REG_GAIN: begin
            gain    <= cfg_write_data[23:0];
            pending <= 1'b1;
          end
          dtb_pkg::REG_PERIOD_0: period[0] <= cfg_write_data;
          dtb_pkg::REG_PERIOD_1: period[1] <= cfg_write_data;
          dtb_pkg::REG_PERIOD_2: period[2] <= cfg_write_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (uw.op)
      dtb_pkg::U_LOAD: begin
        if (accept) begin
          item  <= in_item;
          delta <= 64'd0;
        end
      end
      dtb_pkg::U_MUL_EL, dtb_pkg::U_MUL_LO, dtb_pkg::U_MUL_HI: begin
        prod <= {24'd0, mul_a} * {32'd0, gain};
      end
      dtb_pkg::U_ADD_EL: begin
        delta <= {24'd0, prod[55:16]};
      end
      dtb_pkg::U_BASE: begin
        tval <= dl_sel - {24'd0, per_sel};
      end
      dtb_pkg::U_TRUE: begin
        tval <= item.external_time - tval;
      end
      dtb_pkg::U_ACC_LO: begin
        acc <= last_clock[idx] + {24'd0, prod[55:16]};
      end
      dtb_pkg::U_ACC_HI: begin
        acc <= acc + {prod[47:0], 16'd0};
      end
      dtb_pkg::U_ARM: begin
        last_clock[idx] <= clock_value;
        deadline[idx]   <= item.external_time + {24'd0, per_sel};
      end
      dtb_pkg::U_SPECIAL: begin
        if (gain == dtb_pkg::GAIN_ONE) begin
          delta <= {32'd0, item.elapsed};
        end
      end
      dtb_pkg::U_EMIT: begin
        if (!out_busy) begin
          out_item.clock_now       <= clock_value;
          out_item.dilated_elapsed <= delta;
          out_item.corrected       <= snapped;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/dtb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtb_checker
// Port-level checks of the dilated time base, bound to its top level.
// ----------------------------------------------------------------------------
module dtb_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input dtb_pkg::out_item_t out_item
);

  // A waiting result stays put until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Once an item is taken, the block is busy with it in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

  // A new result appears only at the end of work on an item.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while the block was idle");

endmodule

bind dilated_time_base dtb_checker u_dtb_checker (.*);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dilated time base. A cycle-free predictor tracks
// the scaled clock, the gain, the check periods and the armed checks, and every
// item that the block accepts yields one expected result. Directed items cover
// unity and zero gain, wrap-around, set and re-arm items and snapping checks;
// random runs then give well-formed time sequences with noise under several
// register settings, with bursty input, random output stalls and one long
// output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_CHECKS = 3;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [39:0] PERIOD_MAX = 40'hFF_FFFF_FFFF;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  dtb_pkg::in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  dtb_pkg::out_item_t out_item;
  logic        cfg_write_enable;
  logic [1:0]  cfg_index;
  logic [39:0] cfg_write_data;

  logic [23:0] model_gain = dtb_pkg::GAIN_ONE;
  logic [39:0] model_period [0:2] = '{40'd1000000000, 40'd100000000, 40'd10000000};
  logic [63:0] model_clock = '0;
  logic [63:0] model_arm_clock [0:2];
  logic [63:0] model_deadline [0:2];
  logic        model_rearm = 1'b1;

  dtb_pkg::out_item_t expected_clock_results [$];
  dtb_pkg::out_item_t clock_want;
  int        mismatch_count = 0;
  int        burst_left = 0;
  int        hold_off_cycles = 0;
  int        stall_left = 0;
  int        stall_pct = 0;
  int        cycle_count = 0;
  logic [63:0] ext_now;

  dilated_time_base #(
    .NUM_CHECKS(NUM_CHECKS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index(cfg_index),
    .cfg_write_data(cfg_write_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // (x * g) >> 16, exact, kept modulo 2^64.
  function automatic logic [63:0] q16_scale(logic [63:0] x, logic [23:0] g);
    logic [87:0] prod;
    prod = {24'b0, x} * {64'b0, g};
    return prod[79:16];
  endfunction

  task automatic predict_time_base(dtb_pkg::in_item_t it, output dtb_pkg::out_item_t r);
    logic [63:0] delta;
    logic [63:0] per;
    logic [63:0] true_el;
    logic [63:0] target;
    logic        snapped;
    int          i;
    delta = '0;
    snapped = 1'b0;
    case (it.kind)
      dtb_pkg::KIND_UPDATE: begin
        if (model_gain == dtb_pkg::GAIN_ONE) begin
          delta = {32'b0, it.elapsed};
          model_clock += delta;
        end else if (model_gain != '0) begin
          delta = q16_scale({32'b0, it.elapsed}, model_gain);
          model_clock += delta;
          for (i = 0; i < NUM_CHECKS; i++) begin
            per = {24'b0, model_period[i]};
            if (snapped || model_rearm) begin
              model_arm_clock[i] = model_clock;
              model_deadline[i] = it.external_time + per;
            end else if (it.external_time >= model_deadline[i]) begin
              true_el = it.external_time - (model_deadline[i] - per);
              target = model_arm_clock[i] + q16_scale(true_el, model_gain);
              if (model_clock != target) begin
                model_clock = target;
                snapped = 1'b1;
              end
              model_arm_clock[i] = model_clock;
              model_deadline[i] = it.external_time + per;
            end
          end
          model_rearm = 1'b0;
        end
      end
      dtb_pkg::KIND_SET: begin
        model_clock = it.set_value;
        model_rearm = 1'b1;
      end
      dtb_pkg::KIND_REARM: begin
        model_rearm = 1'b1;
      end
      default: begin
      end
    endcase
    r.clock_now = model_clock;
    r.dilated_elapsed = delta;
    r.corrected = snapped;
  endtask

  function automatic dtb_pkg::in_item_t make_item(logic [1:0] kind, logic [63:0] ext,
                                                  logic [31:0] el, logic [63:0] setv);
    dtb_pkg::in_item_t it;
    it.kind = kind;
    it.external_time = ext;
    it.elapsed = el;
    it.set_value = setv;
    return it;
  endfunction

  task automatic send_item(dtb_pkg::in_item_t it);
    dtb_pkg::out_item_t r;
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    in_valid = 1'b1;
    in_item = it;
    do @(posedge clk); while (in_stall);
    predict_time_base(it, r);
    expected_clock_results.push_back(r);
    burst_left--;
  endtask

  task automatic settle_idle(int tail);
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (expected_clock_results.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [39:0] val);
    @(negedge clk);
    cfg_write_enable = 1'b1;
    cfg_index = idx;
    cfg_write_data = val;
    @(negedge clk);
    cfg_write_enable = 1'b0;
    case (idx)
      dtb_pkg::REG_GAIN: begin
        model_gain = val[23:0];
        model_rearm = 1'b1;
      end
      dtb_pkg::REG_PERIOD_0: model_period[0] = val;
      dtb_pkg::REG_PERIOD_1: model_period[1] = val;
      dtb_pkg::REG_PERIOD_2: model_period[2] = val;
      default: begin
      end
    endcase
  endtask

  task automatic load_settings(logic [23:0] gain, logic [39:0] p0, logic [39:0] p1,
                               logic [39:0] p2);
    settle_idle(8);
    write_reg(dtb_pkg::REG_GAIN, {16'b0, gain});
    write_reg(dtb_pkg::REG_PERIOD_0, p0);
    write_reg(dtb_pkg::REG_PERIOD_1, p1);
    write_reg(dtb_pkg::REG_PERIOD_2, p2);
  endtask

  function automatic logic [23:0] odd_gain(logic [23:0] lo, logic [23:0] hi);
    logic [23:0] g;
    g = 24'($urandom_range(32'(lo), 32'(hi)));
    if (g == dtb_pkg::GAIN_ONE) g = g + 24'd1;
    return g;
  endfunction

  task automatic test_unity_gain();
    send_item(make_item(dtb_pkg::KIND_UPDATE, '0, '0, '1));
    send_item(make_item(dtb_pkg::KIND_UPDATE, '1, '1, '0));
    send_item(make_item(dtb_pkg::KIND_SET, '0, '0, '1));
    send_item(make_item(dtb_pkg::KIND_UPDATE, 64'd5, 32'd1, '0));
    send_item(make_item(dtb_pkg::KIND_REARM, '1, '1, '1));
    send_item(make_item(2'd3, '1, '1, '1));
    send_item(make_item(dtb_pkg::KIND_SET, '1, '1, '0));
  endtask

  task automatic test_gain_extremes();
    settle_idle(8);
    write_reg(dtb_pkg::REG_GAIN, '0);
    send_item(make_item(dtb_pkg::KIND_UPDATE, 64'd100, '1, '1));
    settle_idle(8);
    write_reg(dtb_pkg::REG_GAIN, 40'hFF_FFFF);
    send_item(make_item(dtb_pkg::KIND_UPDATE, 64'd1000, '1, '0));
    send_item(make_item(dtb_pkg::KIND_UPDATE, '1, '1, '0));
    settle_idle(8);
    write_reg(dtb_pkg::REG_GAIN, 40'd1);
    send_item(make_item(dtb_pkg::KIND_UPDATE, 64'd5, '1, '0));
  endtask

  task automatic test_check_snaps();
    int k;
    logic [31:0] el;
    load_settings(24'h018000, 40'd1000, 40'd100, 40'd0);
    ext_now = '0;
    for (k = 0; k < 9; k++) begin
      el = (k == 0) ? 32'd0 : 32'd3 + k;
      ext_now += {32'b0, el};
      send_item(make_item(dtb_pkg::KIND_UPDATE, ext_now, el, '0));
    end
    ext_now = 64'hFFFF_FFFF_FFFF_FF00;
    send_item(make_item(dtb_pkg::KIND_UPDATE, ext_now, 32'd7, '0));
    ext_now += 64'd700;
    send_item(make_item(dtb_pkg::KIND_UPDATE, ext_now, 32'd700, '0));
  endtask

  task automatic random_sequence(int count, int unsigned step_max);
    int       n;
    int       roll;
    dtb_pkg::in_item_t it;
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      it = make_item(dtb_pkg::KIND_UPDATE, {$urandom, $urandom}, $urandom,
                     {$urandom, $urandom});
      if (roll < 4) begin
        it.kind = dtb_pkg::KIND_SET;
      end else if (roll < 7) begin
        it.kind = dtb_pkg::KIND_REARM;
      end else if (roll < 92) begin
        it.elapsed = $urandom_range(0, step_max);
        ext_now += {32'b0, it.elapsed};
        it.external_time = ext_now;
      end else if (roll < 96) begin
        ext_now += {32'b0, it.elapsed};
        it.external_time = ext_now;
      end else begin
        ext_now = it.external_time;
      end
      send_item(it);
    end
  endtask

  task automatic test_input_backpressure();
    load_settings(odd_gain(24'h008000, 24'h020000), 40'd5000, 40'd800, 40'd90);
    ext_now = {$urandom, $urandom};
    hold_off_cycles = 400;
    random_sequence(16, 300);
  endtask

  task automatic test_random_phases();
    int ph;
    for (ph = 0; ph < 9; ph++) begin
      case (ph)
        0: load_settings(odd_gain(24'd1, 24'hFF_FFFF), 40'd20000, 40'd2000, 40'd200);
        1: load_settings(24'h00FFFF, 40'd1, 40'd1, 40'd1);
        2: load_settings(24'h010001, 40'($urandom_range(1, 5000)),
                         40'($urandom_range(1, 5000)), 40'($urandom_range(1, 5000)));
        3: load_settings(24'hFF_FFFF, PERIOD_MAX, PERIOD_MAX, PERIOD_MAX);
        4: load_settings(odd_gain(24'd1, 24'h00FFFF), 40'($urandom_range(1, 100000)),
                         40'($urandom_range(1, 100000)), 40'($urandom_range(1, 100000)));
        5: load_settings(dtb_pkg::GAIN_ONE, 40'($urandom_range(1, 9000)),
                         40'($urandom_range(1, 9000)), 40'($urandom_range(1, 9000)));
        6: load_settings(24'd0, {8'b0, $urandom}, {8'b0, $urandom}, {8'b0, $urandom});
        7: load_settings(odd_gain(24'd1, 24'hFF_FFFF), 40'd3000, 40'd0, 40'd300);
        default: load_settings(odd_gain(24'h010000, 24'h030000),
                               40'($urandom_range(1, 2000)),
                               40'($urandom_range(1, 2000)),
                               40'($urandom_range(1, 2000)));
      endcase
      if ($urandom_range(0, 2) == 0) begin
        ext_now = 64'hFFFF_FFFF_FFF0_0000 + 64'($urandom_range(0, 65535));
      end else begin
        ext_now = {$urandom, $urandom};
      end
      case (ph)
        1: random_sequence(130, 50);
        3: random_sequence(130, 32'hFFFF_FFFF);
        4, 5, 6: random_sequence(130, 10000);
        7, 8: random_sequence(130, 400);
        default: random_sequence(130, 2000);
      endcase
    end
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_stall = 1'b1;
        repeat (hold_off_cycles) @(negedge clk);
        hold_off_cycles = 0;
      end
      if (stall_left == 0) begin
        stall_left = $urandom_range(16, 128);
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 30;
          3: stall_pct = 60;
          default: stall_pct = 85;
        endcase
      end
      stall_left--;
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_clock_results.size() == 0) begin
        $error("unexpected result: clock_now %h", out_item.clock_now);
        mismatch_count++;
      end else begin
        clock_want = expected_clock_results.pop_front();
        if (out_item.clock_now !== clock_want.clock_now) begin
          $error("clock_now: expected %h, got %h", clock_want.clock_now,
                 out_item.clock_now);
          mismatch_count++;
        end
        if (out_item.dilated_elapsed !== clock_want.dilated_elapsed) begin
          $error("dilated_elapsed: expected %h, got %h", clock_want.dilated_elapsed,
                 out_item.dilated_elapsed);
          mismatch_count++;
        end
        if (out_item.corrected !== clock_want.corrected) begin
          $error("corrected: expected %b, got %b", clock_want.corrected,
                 out_item.corrected);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_write_enable = 1'b0;
    cfg_index = dtb_pkg::REG_GAIN;
    cfg_write_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_unity_gain();
    test_gain_extremes();
    test_check_snaps();
    test_input_backpressure();
    test_random_phases();
    settle_idle(60);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
